/* sv/co_sensor_frame_parser_core_defines.svh */
// assertion macros shared by the frame parser rtl
// no dependencies; included by the modules that carry checks
`ifndef CO_SENSOR_FRAME_PARSER_CORE_DEFINES_SVH
`define CO_SENSOR_FRAME_PARSER_CORE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication under synchronous active-low reset
`define COSFP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("frame parser check failed");
// next-cycle implication under synchronous active-low reset
`define COSFP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("frame parser check failed");
`else
`define COSFP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define COSFP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/cosfp_pkg.sv */
// shared types and constants for the sensor frame parser
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
package cosfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int PPM_W    = 16;
    localparam int POS_W    = 3;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 16;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    // frame positions: header is position 0, checksum is position 5
    localparam logic [POS_W-1:0] POS_IDLE     = 3'd0;
    localparam logic [POS_W-1:0] POS_PPM_HI   = 3'd1;
    localparam logic [POS_W-1:0] POS_PPM_LO   = 3'd2;
    localparam logic [POS_W-1:0] POS_CHECKSUM = 3'd5;

    // register indexes
    localparam logic [CFG_A_W-1:0] CFG_HEADER  = 1'd0;
    localparam logic [CFG_A_W-1:0] CFG_MAX_PPM = 1'd1;

    localparam logic [BYTE_W-1:0] HEADER_RST  = 8'h2C;
    localparam logic [PPM_W-1:0]  MAX_PPM_RST = 16'd1000;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_CSUM  = 2'd1,
        STATUS_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] header;
        logic [PPM_W-1:0]  max_ppm;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] computed_sum;
        logic [BYTE_W-1:0] received_sum;
        logic [PPM_W-1:0]  ppm_value;
        t_status           frame_status;
    } t_result;

endpackage

/* sv/co_sensor_frame_parser_core.sv */
// Sensor frame parser top level. Takes one serial byte per beat and emits one
// status beat for each complete six-byte frame (header, ppm high, ppm low, two
// range bytes, checksum). One byte is accepted every clock cycle unless the input
// side stalls; each byte is held in an input register, decoded there against the
// frame state, and a checksum byte then loads the result register. The input
// side stalls only when a checksum byte must load the result register while it
// still holds a beat the sink has not taken. Registers are to be written by the
// user only while no frame is in progress; the block does not enforce this.
// Depends on cosfp_pkg, cosfp_cfg_regs, cosfp_frame_track, cosfp_out_reg.
`timescale 1ns / 1ps
module co_sensor_frame_parser_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [cosfp_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  logic [cosfp_pkg::CFG_D_W-1:0]   i_cfg_data,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cosfp_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [7:0] rx_byte
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] frame_status, [17:2] ppm_value, [25:18] received_sum,
    // [33:26] computed_sum, [39:34] zero
    output logic [cosfp_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    cosfp_pkg::t_cfg              w_cfg;
    cosfp_pkg::t_result           w_result;
    cosfp_pkg::t_result           w_out_result;
    logic                         w_hit;
    logic                         w_advance;
    logic                         w_out_valid;
    logic                         r_in_valid;
    logic [cosfp_pkg::BYTE_W-1:0] r_in_byte;

    // input register waits only if its byte closes a frame into a stalled full slot
    assign w_advance     = r_in_valid && (!w_hit || !w_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata[cosfp_pkg::BYTE_W-1:0];
        end
    end

    cosfp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    cosfp_frame_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .i_cfg    (w_cfg),
        .o_hit    (w_hit),
        .o_result (w_result)
    );

    cosfp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_hit),
        .i_result (w_result),
        .i_ready  (m_axis_tready),
        .o_valid  (w_out_valid),
        .o_result (w_out_result)
    );

    // pack result beat, first field lowest
    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {6'd0, w_out_result.computed_sum, w_out_result.received_sum,
                            w_out_result.ppm_value, w_out_result.frame_status};

endmodule

/* sv/cosfp_cfg_regs.sv */
// configuration registers: header byte and ppm limit
// depends on cosfp_pkg
`timescale 1ns / 1ps
module cosfp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cosfp_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [cosfp_pkg::CFG_D_W-1:0] i_cfg_data,
    output cosfp_pkg::t_cfg               o_cfg
);

    cosfp_pkg::t_cfg r_cfg;

    // register writes, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header  <= cosfp_pkg::HEADER_RST;
            r_cfg.max_ppm <= cosfp_pkg::MAX_PPM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                cosfp_pkg::CFG_HEADER: begin
                    r_cfg.header <= i_cfg_data[cosfp_pkg::BYTE_W-1:0];
                end
                cosfp_pkg::CFG_MAX_PPM: begin
                    r_cfg.max_ppm <= i_cfg_data[cosfp_pkg::PPM_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/cosfp_frame_track.sv */
// frame tracker: byte position, running sum, ppm bytes and result decode
// depends on cosfp_pkg and the defines header
`timescale 1ns / 1ps
`include "co_sensor_frame_parser_core_defines.svh"
module cosfp_frame_track (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [cosfp_pkg::BYTE_W-1:0] i_byte,
    input  cosfp_pkg::t_cfg              i_cfg,
    output logic                         o_hit,
    output cosfp_pkg::t_result           o_result
);

    logic [cosfp_pkg::POS_W-1:0]  r_pos;
    logic [cosfp_pkg::POS_W-1:0]  n_pos;
    logic [cosfp_pkg::BYTE_W-1:0] r_sum;
    logic [cosfp_pkg::BYTE_W-1:0] n_sum;
    logic [cosfp_pkg::BYTE_W-1:0] r_level_high;
    logic [cosfp_pkg::BYTE_W-1:0] r_level_low;
    logic                         w_is_hdr;
    logic [cosfp_pkg::PPM_W-1:0]  w_ppm;

    assign w_is_hdr = (i_byte == i_cfg.header);
    // a non-header byte at or past the checksum slot closes the frame
    assign o_hit    = !w_is_hdr && (r_pos >= cosfp_pkg::POS_CHECKSUM);
    assign w_ppm    = {r_level_high, r_level_low};

    // result decode: checksum mismatch wins over the range check
    always_comb begin
        o_result.ppm_value    = w_ppm;
        o_result.received_sum = i_byte;
        o_result.computed_sum = r_sum;
        if (r_sum != i_byte) begin
            o_result.frame_status = cosfp_pkg::STATUS_CSUM;
        end else if (w_ppm > i_cfg.max_ppm) begin
            o_result.frame_status = cosfp_pkg::STATUS_RANGE;
        end else begin
            o_result.frame_status = cosfp_pkg::STATUS_OK;
        end
    end

    // next position and sum
    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (w_is_hdr) begin
            n_pos = cosfp_pkg::POS_PPM_HI;
            n_sum = i_byte;
        end else if (r_pos == cosfp_pkg::POS_IDLE) begin
            n_pos = r_pos;
        end else if (r_pos < cosfp_pkg::POS_CHECKSUM) begin
            n_pos = r_pos + 3'd1;
            n_sum = r_sum + i_byte;
        end else begin
            n_pos = cosfp_pkg::POS_IDLE;
            n_sum = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= cosfp_pkg::POS_IDLE;
            r_sum <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    // ppm byte capture
    always_ff @(posedge i_clk) begin
        if (i_step && !w_is_hdr && (r_pos == cosfp_pkg::POS_PPM_HI)) begin
            r_level_high <= i_byte;
        end
        if (i_step && !w_is_hdr && (r_pos == cosfp_pkg::POS_PPM_LO)) begin
            r_level_low <= i_byte;
        end
    end

    `COSFP_ASSERT_NXT(a_hdr_restart, i_clk, i_rst_n, i_step && w_is_hdr, (r_pos == cosfp_pkg::POS_PPM_HI) && (r_sum == $past(i_byte)))
    `COSFP_ASSERT_NXT(a_close_clears, i_clk, i_rst_n, i_step && o_hit, (r_pos == cosfp_pkg::POS_IDLE) && (r_sum == '0))
    `COSFP_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= cosfp_pkg::POS_CHECKSUM)

endmodule

/* sv/cosfp_out_reg.sv */
// result register driving the master-side stream
// depends on cosfp_pkg and the defines header
`timescale 1ns / 1ps
`include "co_sensor_frame_parser_core_defines.svh"
module cosfp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  cosfp_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output cosfp_pkg::t_result o_result
);

    logic               r_valid;
    cosfp_pkg::t_result r_result;

    // valid flag: set on load, cleared when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `COSFP_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_load, !r_valid || i_ready)

endmodule

/* tb/tb_co_sensor_frame_parser_core.sv */
// testbench for the sensor frame parser: directed and random byte streams, checked beat by beat
// depends on cosfp_pkg and co_sensor_frame_parser_core
`timescale 1ns / 1ps
module tb_co_sensor_frame_parser_core;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 300;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [cosfp_pkg::CFG_A_W-1:0]     i_cfg_addr;
    logic [cosfp_pkg::CFG_D_W-1:0]     i_cfg_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [cosfp_pkg::S_TDATA_W-1:0]   s_axis_tdata;   // [7:0] rx_byte
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    // [1:0] frame_status, [17:2] ppm_value, [25:18] received_sum,
    // [33:26] computed_sum, [39:34] zero
    logic [cosfp_pkg::M_TDATA_W-1:0]   m_axis_tdata;

    co_sensor_frame_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // parser shadow: register copies and frame state
    logic [cosfp_pkg::BYTE_W-1:0] hdr_reg   = cosfp_pkg::HEADER_RST;
    logic [cosfp_pkg::PPM_W-1:0]  limit_reg = cosfp_pkg::MAX_PPM_RST;
    logic [cosfp_pkg::POS_W-1:0]  pos       = cosfp_pkg::POS_IDLE;
    logic [cosfp_pkg::BYTE_W-1:0] sum_acc   = '0;
    logic [cosfp_pkg::BYTE_W-1:0] lvl_hi    = '0;
    logic [cosfp_pkg::BYTE_W-1:0] lvl_lo    = '0;

    logic [cosfp_pkg::BYTE_W-1:0] pending_bytes[$];
    cosfp_pkg::t_result           expected_reports[$];

    int  mismatches = 0;
    int  cycles     = 0;
    bit  in_taken   = 1'b0;
    bit  out_taken  = 1'b0;
    int  in_gap     = 0;
    int  in_calm    = 0;
    int  out_hold   = 0;
    int  out_calm   = 0;

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // advance the frame state by one received byte, queue a report on the checksum byte
    function automatic void parse_byte(input logic [cosfp_pkg::BYTE_W-1:0] b);
        cosfp_pkg::t_result r;
        if (b == hdr_reg) begin
            pos     = cosfp_pkg::POS_PPM_HI;
            sum_acc = b;
        end else if (pos != cosfp_pkg::POS_IDLE) begin
            if (pos < cosfp_pkg::POS_CHECKSUM) begin
                if (pos == cosfp_pkg::POS_PPM_HI)
                    lvl_hi = b;
                else if (pos == cosfp_pkg::POS_PPM_LO)
                    lvl_lo = b;
                sum_acc = sum_acc + b;
                pos     = pos + 3'd1;
            end else begin
                r.ppm_value    = {lvl_hi, lvl_lo};
                r.received_sum = b;
                r.computed_sum = sum_acc;
                // checksum wins over the range test
                if (sum_acc != b)
                    r.frame_status = cosfp_pkg::STATUS_CSUM;
                else if (r.ppm_value > limit_reg)
                    r.frame_status = cosfp_pkg::STATUS_RANGE;
                else
                    r.frame_status = cosfp_pkg::STATUS_OK;
                expected_reports.push_back(r);
                pos     = cosfp_pkg::POS_IDLE;
                sum_acc = '0;
            end
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            calm = $urandom_range(20, 80);
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // sample both sides, update the shadow, compare result beats
    always @(posedge i_clk) begin
        cosfp_pkg::t_result got;
        cosfp_pkg::t_result want;
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_co_sensor_frame_parser_core failed");
            $finish;
        end
        if (i_rst_n && i_cfg_we) begin
            if (i_cfg_addr == cosfp_pkg::CFG_HEADER)
                hdr_reg = i_cfg_data[cosfp_pkg::BYTE_W-1:0];
            else if (i_cfg_addr == cosfp_pkg::CFG_MAX_PPM)
                limit_reg = i_cfg_data[cosfp_pkg::PPM_W-1:0];
        end
        out_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (out_taken) begin
            got = m_axis_tdata[33:0];
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result beat, expected none actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                check_field("frame_status", want.frame_status, got.frame_status);
                check_field("ppm_value", want.ppm_value, got.ppm_value);
                check_field("received_sum", want.received_sum, got.received_sum);
                check_field("computed_sum", want.computed_sum, got.computed_sum);
            end
        end
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
            parse_byte(s_axis_tdata);
    end

    // byte driver, fed from the pending queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (in_taken)
                in_gap = pick_gap(in_calm);
            if (in_gap > 0) begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_bytes.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink with random stalls
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (out_taken || $urandom_range(0, 19) == 0)
                out_hold = pick_gap(out_calm);
        end
    end

    // one frame: header, ppm big endian, two range bytes, checksum xor flip
    task automatic push_frame(input logic [cosfp_pkg::BYTE_W-1:0] hdr,
                              input logic [cosfp_pkg::PPM_W-1:0] ppm,
                              input logic [cosfp_pkg::BYTE_W-1:0] r1,
                              input logic [cosfp_pkg::BYTE_W-1:0] r2,
                              input logic [cosfp_pkg::BYTE_W-1:0] flip);
        logic [cosfp_pkg::BYTE_W-1:0] csum;
        csum = hdr + ppm[15:8] + ppm[7:0] + r1 + r2;
        pending_bytes.push_back(hdr);
        pending_bytes.push_back(ppm[15:8]);
        pending_bytes.push_back(ppm[7:0]);
        pending_bytes.push_back(r1);
        pending_bytes.push_back(r2);
        pending_bytes.push_back(csum ^ flip);
    endtask

    task automatic write_reg(input logic [cosfp_pkg::CFG_A_W-1:0] idx,
                             input logic [cosfp_pkg::CFG_D_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // send everything, close an open frame, wait for every report and the pipeline
    task automatic drain_parser();
        while (pending_bytes.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (pos != cosfp_pkg::POS_IDLE) begin
            pending_bytes.push_back(hdr_reg ^ 8'h01);
            @(posedge i_clk);
            while (pending_bytes.size() != 0 || s_axis_tvalid)
                @(posedge i_clk);
        end
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // mostly well-formed frames with random content, some cut short, some line noise
    task automatic random_phase(input int n_items);
        int made;
        int sel;
        int len;
        logic [cosfp_pkg::PPM_W-1:0]  ppm;
        logic [cosfp_pkg::BYTE_W-1:0] flip;
        made = 0;
        while (made < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                case ($urandom_range(0, 3))
                    0: ppm = 16'($urandom);
                    1: ppm = 16'(limit_reg + $urandom_range(0, 4) - 2);
                    2: ppm = $urandom_range(0, 1) ? 16'h0000 : {8'($urandom), 8'h00};
                    default: ppm = $urandom_range(0, 1) ? 16'hFFFF
                                                        : 16'($urandom_range(0, 2000));
                endcase
                flip = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                push_frame(hdr_reg, ppm, 8'($urandom), 8'($urandom), flip);
                made += 6;
            end else if (sel < 85) begin
                len = $urandom_range(1, 5);
                pending_bytes.push_back(hdr_reg);
                repeat (len - 1) pending_bytes.push_back(8'($urandom));
                made += len;
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) pending_bytes.push_back(8'($urandom));
                made += len;
            end
        end
    endtask

    initial begin
        logic [cosfp_pkg::BYTE_W-1:0] hdr_set[5];
        logic [cosfp_pkg::PPM_W-1:0]  lim_set[5];
        int k;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = cosfp_pkg::CFG_HEADER;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        hdr_set = '{8'h00, 8'hFF, 8'($urandom), 8'hAA, cosfp_pkg::HEADER_RST};
        lim_set = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h8000, cosfp_pkg::MAX_PPM_RST};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: idle junk at both extremes
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        // ppm right at the limit, then one above
        push_frame(cosfp_pkg::HEADER_RST, 16'd1000, 8'h00, 8'hFF, 8'h00);
        push_frame(cosfp_pkg::HEADER_RST, 16'd1001, 8'h80, 8'h7F, 8'h00);
        // header where the checksum belongs restarts the frame
        pending_bytes.push_back(cosfp_pkg::HEADER_RST);
        pending_bytes.push_back(8'h12);
        pending_bytes.push_back(8'h34);
        pending_bytes.push_back(8'h56);
        pending_bytes.push_back(8'h78);
        pending_bytes.push_back(cosfp_pkg::HEADER_RST);
        // restarted frame ends in a bad checksum with ppm over the limit
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(8'h00);

        random_phase(PHASE_ITEMS);
        for (k = 0; k < 5; k++) begin
            drain_parser();
            write_reg(cosfp_pkg::CFG_HEADER, {8'h00, hdr_set[k]});
            write_reg(cosfp_pkg::CFG_MAX_PPM, lim_set[k]);
            random_phase(PHASE_ITEMS);
        end
        drain_parser();

        if (mismatches == 0)
            $display("tb_co_sensor_frame_parser_core passed");
        else
            $display("tb_co_sensor_frame_parser_core failed");
        $finish;
    end

endmodule
